/* hdl/mad_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mad_pkg
// Shared widths, reset values, queue depth and types for the moving average
// and deviation block.
// ---------------------------------------------------------------------------
package mad_pkg;

   // Fixed field widths
   localparam int SAMPLE_W = 32;
   localparam int LEN_W    = 7;

   // Default ring depth and register reset value
   localparam int              MAX_WINDOW_DEFAULT = 64;
   localparam logic [LEN_W-1:0] WINDOW_LEN_RESET  = 7'd60;

   // Depth of the queue between the front and the back end
   localparam int QUEUE_DEPTH = 4;

   // Saturation bounds of a Q16.16 word
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;

   // Queue fill status
   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   // Back end sequencer
   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIVIDE,
      BACK_FINISH,
      BACK_DELIVER
   } back_state_type;

endpackage

/* hdl/mad_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mad_front
// Sample ring, running total, write pointer and window length register.
// Accepts samples, works out the divisor and queues each updated total.
// ---------------------------------------------------------------------------
module mad_front #(
   parameter int  MAX_WINDOW = mad_pkg::MAX_WINDOW_DEFAULT,
   localparam int CNT_W      = $clog2(MAX_WINDOW) + 1,
   localparam int TOTAL_W    = mad_pkg::SAMPLE_W + $clog2(MAX_WINDOW)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mad_pkg::LEN_W-1:0]           csr_window_len,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic signed [mad_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                q_push,
   output logic signed [TOTAL_W-1:0]           q_total,
   output logic signed [mad_pkg::SAMPLE_W-1:0] q_sample,
   output logic [CNT_W-1:0]                    q_divisor,
   input  logic                                q_pop
);
   import mad_pkg::*;

   localparam int ADDR_W = $clog2(MAX_WINDOW);
   localparam int CMP_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam int CRED_W = $clog2(QUEUE_DEPTH + 1);

   logic signed [SAMPLE_W-1:0] ring_ff [MAX_WINDOW];
   logic signed [SAMPLE_W-1:0] rd_ff;

   logic [LEN_W-1:0]           window_len_ff, window_len_in;
   logic                       clr_ff, clr_in;
   logic [ADDR_W-1:0]          clr_addr_ff, clr_addr_in;
   logic [ADDR_W-1:0]          ptr_ff, ptr_in;
   logic                       win_full_ff, win_full_in;
   logic                       s1_valid_ff, s1_valid_in;
   logic signed [SAMPLE_W-1:0] s1_sample_ff;
   logic [CNT_W-1:0]           s1_div_ff;
   logic signed [TOTAL_W-1:0]  total_ff, total_in;
   logic [CRED_W-1:0]          credit_ff, credit_in;

   logic                       accept;
   logic [CMP_W-1:0]           len_wide;
   logic [CNT_W-1:0]           eff_len;
   logic [CNT_W-1:0]           ptr_inc;
   logic [CNT_W-1:0]           divisor;
   logic                       wrap;
   logic                       mem_we;
   logic [ADDR_W-1:0]          mem_addr;
   logic signed [SAMPLE_W-1:0] mem_wdata;

   // Handshakes
   assign csr_ready = 1'b1;
   assign req_full  = clr_ff || (credit_ff == CRED_W'(QUEUE_DEPTH));
   assign accept    = req_push && !req_full;

   // Clamp the window length and work out pointer advance and divisor
   always_comb begin
      len_wide = CMP_W'(window_len_ff);
      if (len_wide >= CMP_W'(MAX_WINDOW)) begin
         eff_len = CNT_W'(MAX_WINDOW);
      end else if (window_len_ff == '0) begin
         eff_len = CNT_W'(1);
      end else begin
         eff_len = CNT_W'(window_len_ff);
      end
      ptr_inc = {1'b0, ptr_ff} + CNT_W'(1);
      divisor = win_full_ff ? eff_len : ptr_inc;
      wrap    = (ptr_inc >= eff_len);
   end

   // Next state of control and the running total
   always_comb begin
      window_len_in = csr_valid ? csr_window_len : window_len_ff;

      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(MAX_WINDOW - 1)) begin
            clr_in = 1'b0;
         end
      end

      ptr_in      = ptr_ff;
      win_full_in = win_full_ff;
      if (accept) begin
         ptr_in      = wrap ? '0 : ptr_inc[ADDR_W-1:0];
         win_full_in = win_full_ff | wrap;
      end

      s1_valid_in = accept;

      total_in = total_ff;
      if (s1_valid_ff) begin
         total_in = total_ff + TOTAL_W'(s1_sample_ff) - TOTAL_W'(rd_ff);
      end

      credit_in = credit_ff + CRED_W'(accept) - CRED_W'(q_pop);
   end

   // Ring write port: zero sweep after reset, then one sample per transfer
   assign mem_we    = clr_ff || accept;
   assign mem_addr  = clr_ff ? clr_addr_ff : ptr_ff;
   assign mem_wdata = clr_ff ? '0 : req_sample;

   // Ring memory, old entry read out as the new one goes in
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_ff[mem_addr] <= mem_wdata;
      end
      rd_ff <= ring_ff[ptr_ff];
   end

   // Stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff <= req_sample;
         s1_div_ff    <= divisor;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= WINDOW_LEN_RESET;
         clr_ff        <= 1'b1;
         clr_addr_ff   <= '0;
         ptr_ff        <= '0;
         win_full_ff   <= 1'b0;
         s1_valid_ff   <= 1'b0;
         total_ff      <= '0;
         credit_ff     <= '0;
      end else begin
         window_len_ff <= window_len_in;
         clr_ff        <= clr_in;
         clr_addr_ff   <= clr_addr_in;
         ptr_ff        <= ptr_in;
         win_full_ff   <= win_full_in;
         s1_valid_ff   <= s1_valid_in;
         total_ff      <= total_in;
         credit_ff     <= credit_in;
      end
   end

   // Hand the updated total to the queue
   assign q_push    = s1_valid_ff;
   assign q_total   = total_in;
   assign q_sample  = s1_sample_ff;
   assign q_divisor = s1_div_ff;

endmodule

/* hdl/mad_queue.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mad_queue
// Short first-in first-out queue between the front and the back end.
// ---------------------------------------------------------------------------
module mad_queue #(
   parameter int WIDTH = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [WIDTH-1:0]          push_data,
   input  logic                      pop,
   output logic [WIDTH-1:0]          pop_data,
   output mad_pkg::queue_status_type status
);
   import mad_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Status and head of queue
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_data     = slots_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   // Store incoming entries
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* hdl/mad_back.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mad_back
// Bit-serial signed divide of the running total, saturation of the mean,
// deviation and the result output register.
// ---------------------------------------------------------------------------
module mad_back #(
   parameter int  MAX_WINDOW = mad_pkg::MAX_WINDOW_DEFAULT,
   localparam int CNT_W      = $clog2(MAX_WINDOW) + 1,
   localparam int TOTAL_W    = mad_pkg::SAMPLE_W + $clog2(MAX_WINDOW)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mad_pkg::queue_status_type           q_status,
   input  logic signed [TOTAL_W-1:0]           q_total,
   input  logic signed [mad_pkg::SAMPLE_W-1:0] q_sample,
   input  logic [CNT_W-1:0]                    q_divisor,
   output logic                                q_pop,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [mad_pkg::SAMPLE_W-1:0] rsp_mean,
   output logic signed [mad_pkg::SAMPLE_W-1:0] rsp_deviation
);
   import mad_pkg::*;

   localparam int STEP_W = $clog2(TOTAL_W + 1);
   localparam int QS_W   = TOTAL_W + 1;
   localparam int DEV_W  = SAMPLE_W + 1;

   back_state_type             state_ff, state_in;
   logic                       neg_ff, neg_in;
   logic [TOTAL_W-1:0]         quo_ff, quo_in;
   logic [CNT_W-1:0]           rem_ff, rem_in;
   logic [CNT_W-1:0]           div_ff, div_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic signed [SAMPLE_W-1:0] mean_ff, mean_in;
   logic                       out_valid_ff, out_valid_in;
   logic signed [SAMPLE_W-1:0] out_mean_ff, out_mean_in;
   logic signed [SAMPLE_W-1:0] out_dev_ff, out_dev_in;

   logic [CNT_W:0]             rem_sh;
   logic [CNT_W:0]             div_ext;
   logic signed [QS_W-1:0]     quo_s;
   logic signed [DEV_W-1:0]    dev_full;
   logic                       out_load;

   // Sequencer: pop, divide one bit a cycle, saturate, deliver
   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      sample_in    = sample_ff;
      step_in      = step_ff;
      mean_in      = mean_ff;
      q_pop        = 1'b0;
      out_load     = 1'b0;
      rem_sh       = {rem_ff, quo_ff[TOTAL_W-1]};
      div_ext      = {1'b0, div_ff};
      quo_s        = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      dev_full     = DEV_W'(sample_ff) - DEV_W'(mean_ff);

      unique case (state_ff)
         BACK_IDLE: begin
            if (!q_status.empty) begin
               q_pop     = 1'b1;
               neg_in    = q_total[TOTAL_W-1];
               quo_in    = q_total[TOTAL_W-1] ? TOTAL_W'(-q_total) : TOTAL_W'(q_total);
               rem_in    = '0;
               div_in    = q_divisor;
               sample_in = q_sample;
               step_in   = '0;
               state_in  = BACK_DIVIDE;
            end
         end
         BACK_DIVIDE: begin
            // Restoring step on the magnitude
            if (rem_sh >= div_ext) begin
               rem_in = CNT_W'(rem_sh - div_ext);
               quo_in = {quo_ff[TOTAL_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[CNT_W-1:0];
               quo_in = {quo_ff[TOTAL_W-2:0], 1'b0};
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(TOTAL_W - 1)) begin
               state_in = BACK_FINISH;
            end
         end
         BACK_FINISH: begin
            // Restore the sign and clamp the mean to 32 bits
            if (quo_s > QS_W'(SAMPLE_MAX)) begin
               mean_in = SAMPLE_MAX;
            end else if (quo_s < QS_W'(SAMPLE_MIN)) begin
               mean_in = SAMPLE_MIN;
            end else begin
               mean_in = quo_s[SAMPLE_W-1:0];
            end
            state_in = BACK_DELIVER;
         end
         BACK_DELIVER: begin
            // Hold until the output register is free
            if (!out_valid_ff || rsp_pop) begin
               out_load = 1'b1;
               state_in = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   // Output register with saturated deviation
   always_comb begin
      out_valid_in = out_valid_ff;
      out_mean_in  = out_mean_ff;
      out_dev_in   = out_dev_ff;
      if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
      if (out_load) begin
         out_valid_in = 1'b1;
         out_mean_in  = mean_ff;
         if (dev_full > DEV_W'(SAMPLE_MAX)) begin
            out_dev_in = SAMPLE_MAX;
         end else if (dev_full < DEV_W'(SAMPLE_MIN)) begin
            out_dev_in = SAMPLE_MIN;
         end else begin
            out_dev_in = dev_full[SAMPLE_W-1:0];
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      neg_ff      <= neg_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      sample_ff   <= sample_in;
      step_ff     <= step_in;
      mean_ff     <= mean_in;
      out_mean_ff <= out_mean_in;
      out_dev_ff  <= out_dev_in;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_mean      = out_mean_ff;
   assign rsp_deviation = out_dev_ff;

endmodule

/* hdl/moving_average_deviation_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// moving_average_deviation_top
// Sliding-window mean of signed Q16.16 samples and each sample's deviation.
// ---------------------------------------------------------------------------
// Usage:
//   req_ channel is a queue write side: a sample transfers when req_push is
//   high and req_full is low. rsp_ channel is a queue read side: while
//   rsp_empty is low, rsp_mean and rsp_deviation hold the oldest result,
//   which transfers when rsp_pop is high. csr_window_len is written when
//   csr_valid and csr_ready are high; write it only while the block is idle.
//   A new sample is taken while req_full is low, even while the back end
//   is still dividing an earlier total. The back end takes one queued total
//   at a time, works it through the one-bit-per-cycle restoring divider and
//   delivers the result before it pops the next. A four-entry queue sits
//   between the ring update and the divider, so samples keep arriving while
//   a result waits. After reset the ring is swept to zero, one slot at a
//   time, with req_full high; the window length returns to 60. When the
//   receiver stalls, the result waits in the output register, the divider
//   holds its next result, and req_full rises once the queue is committed.
// ---------------------------------------------------------------------------
module moving_average_deviation_top #(
   parameter int MAX_WINDOW = mad_pkg::MAX_WINDOW_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mad_pkg::LEN_W-1:0]           csr_window_len,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic signed [mad_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [mad_pkg::SAMPLE_W-1:0] rsp_mean,
   output logic signed [mad_pkg::SAMPLE_W-1:0] rsp_deviation
);
   import mad_pkg::*;

   localparam int CNT_W   = $clog2(MAX_WINDOW) + 1;
   localparam int TOTAL_W = SAMPLE_W + $clog2(MAX_WINDOW);
   localparam int ENTRY_W = TOTAL_W + SAMPLE_W + CNT_W;

   logic                       q_push;
   logic                       q_pop;
   logic signed [TOTAL_W-1:0]  f_total;
   logic signed [SAMPLE_W-1:0] f_sample;
   logic [CNT_W-1:0]           f_divisor;
   logic [ENTRY_W-1:0]         q_wdata;
   logic [ENTRY_W-1:0]         q_rdata;
   queue_status_type           q_status;

   // Front end: ring, total and pointer
   mad_front #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_window_len (csr_window_len),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_sample     (req_sample),
      .q_push         (q_push),
      .q_total        (f_total),
      .q_sample       (f_sample),
      .q_divisor      (f_divisor),
      .q_pop          (q_pop)
   );

   // Pack queue entries
   assign q_wdata = {f_total, f_sample, f_divisor};

   mad_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .status    (q_status)
   );

   // Back end: divide, saturate, deliver
   mad_back #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .q_total       (q_rdata[ENTRY_W-1 -: TOTAL_W]),
      .q_sample      (q_rdata[CNT_W +: SAMPLE_W]),
      .q_divisor     (q_rdata[CNT_W-1:0]),
      .q_pop         (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_mean      (rsp_mean),
      .rsp_deviation (rsp_deviation)
   );

   // Credit accounting keeps the queue from overflowing
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("queue written while full");

   // Back end only pops a waiting entry
   a_queue_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("queue popped while empty");

   // Ring sweep blocks input straight after reset
   a_sweep_after_reset: assert property (@(posedge clock)
      reset |=> req_full)
      else $error("input open before ring sweep");

endmodule

/* tb/sv/moving_average_deviation_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// moving_average_deviation_checker
// Watches the sample, result and register channels of the moving average
// block. Keeps its own ring, running total and pointer. Works out the mean
// and deviation of each sample transfer, then compares each result transfer
// with the oldest one still owed. Hands the number of mismatches and of
// results still owed to the testbench top.
// ---------------------------------------------------------------------------
module moving_average_deviation_checker #(
   parameter int MAX_WINDOW = mad_pkg::MAX_WINDOW_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [mad_pkg::LEN_W-1:0]           csr_window_len,
   input  logic                                req_push,
   input  logic                                req_full,
   input  logic signed [mad_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                rsp_empty,
   input  logic                                rsp_pop,
   input  logic signed [mad_pkg::SAMPLE_W-1:0] rsp_mean,
   input  logic signed [mad_pkg::SAMPLE_W-1:0] rsp_deviation,
   output int                                  mismatches,
   output int                                  results_owed
);
   import mad_pkg::*;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] mean;
      logic signed [SAMPLE_W-1:0] deviation;
   } window_stats_type;

   // Shadow of the block state
   logic signed [SAMPLE_W-1:0] ring [MAX_WINDOW];
   longint                     window_total;
   int unsigned                write_slot;
   bit                         wrapped_once;
   logic [LEN_W-1:0]           window_len;

   // Results owed, oldest first
   window_stats_type stats_due [$];
   int               fail_count   = 0;
   int               result_count = 0;

   // Clamp a wide value into the Q16.16 word range
   function automatic logic signed [SAMPLE_W-1:0] clamp_q16(input longint value);
      if (value > longint'(SAMPLE_MAX))
         return SAMPLE_MAX;
      if (value < longint'(SAMPLE_MIN))
         return SAMPLE_MIN;
      return value[SAMPLE_W-1:0];
   endfunction

   task automatic report_mismatch(input string what);
      if (fail_count < 40)
         $display("%0t ns checker: %s", $time, what);
      fail_count++;
   endtask

   // Replace the oldest slot, update the total and queue the mean and deviation
   task automatic advance_window(input logic signed [SAMPLE_W-1:0] sample);
      window_stats_type stats;
      int unsigned      eff_len;
      longint           quotient;
      eff_len = window_len;
      if (eff_len >= MAX_WINDOW)
         eff_len = MAX_WINDOW;
      if (eff_len == 0)
         eff_len = 1;
      if (write_slot >= MAX_WINDOW)
         write_slot = 0;
      window_total = window_total - longint'(ring[write_slot]) + longint'(sample);
      ring[write_slot] = sample;
      write_slot++;
      // Divide by the count so far until the first wrap, then by the length
      if (wrapped_once)
         quotient = window_total / longint'(eff_len);
      else
         quotient = window_total / longint'(write_slot);
      stats.mean = clamp_q16(quotient);
      if (write_slot >= eff_len) begin
         write_slot   = 0;
         wrapped_once = 1'b1;
      end
      stats.deviation = clamp_q16(longint'(sample) - longint'(stats.mean));
      stats_due.push_back(stats);
   endtask

   always @(posedge clock) begin
      window_stats_type want;
      if (reset) begin
         foreach (ring[i])
            ring[i] = '0;
         window_total = 0;
         write_slot   = 0;
         wrapped_once = 1'b0;
         window_len   = WINDOW_LEN_RESET;
         stats_due.delete();
      end else begin
         // Register transfer
         if (csr_valid && csr_ready)
            window_len = csr_window_len;
         // Sample transfer
         if (req_push && !req_full)
            advance_window(req_sample);
         // Result transfer
         if (rsp_pop && !rsp_empty) begin
            if (stats_due.size() == 0) begin
               report_mismatch($sformatf("unexpected result: mean %0d deviation %0d",
                                         rsp_mean, rsp_deviation));
            end else begin
               want = stats_due.pop_front();
               if (rsp_mean !== want.mean)
                  report_mismatch($sformatf("result %0d mean: got %0d, expected %0d",
                                            result_count, rsp_mean, want.mean));
               if (rsp_deviation !== want.deviation)
                  report_mismatch($sformatf("result %0d deviation: got %0d, expected %0d",
                                            result_count, rsp_deviation,
                                            want.deviation));
            end
            result_count++;
         end
      end
      results_owed <= stats_due.size();
      mismatches   <= fail_count;
   end

endmodule

/* tb/sv/tb_moving_average_deviation_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_moving_average_deviation_top
// Drives the moving average block with a directed run through the sample
// extremes, a zero window length and a window shrunk over stale entries,
// then random phases of samples under random window lengths, some oversized.
// Sender bursts, receiver stalls and one long receiver hold-off shape the
// traffic; the checker beside the block predicts and compares.
// ---------------------------------------------------------------------------
module tb_moving_average_deviation_top;
   import mad_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 650;
   localparam int HOLD_CYCLES  = 1500;
   localparam int DRAIN_CYCLES = 60;

   typedef enum int {
      MIX_ANY,
      MIX_HIGH,
      MIX_LOW,
      MIX_NEAR_ZERO
   } sample_mix_type;

   logic                       clock;
   logic                       reset          = 1'b1;
   logic                       csr_valid      = 1'b0;
   logic                       csr_ready;
   logic [LEN_W-1:0]           csr_window_len = '0;
   logic                       req_push       = 1'b0;
   logic                       req_full;
   logic signed [SAMPLE_W-1:0] req_sample     = '0;
   logic                       rsp_empty;
   logic                       rsp_pop        = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_mean;
   logic signed [SAMPLE_W-1:0] rsp_deviation;

   int          checker_mismatches;
   int          results_owed;
   int          random_sent = 0;
   int          burst_left  = 0;
   int          cycle_count = 0;
   logic        hold_off    = 1'b0;
   bit [15:0]   stall_tick  = '0;

   moving_average_deviation_top DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_window_len (csr_window_len),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_sample     (req_sample),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_mean       (rsp_mean),
      .rsp_deviation  (rsp_deviation)
   );

   moving_average_deviation_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_window_len (csr_window_len),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_sample     (req_sample),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_mean       (rsp_mean),
      .rsp_deviation  (rsp_deviation),
      .mismatches     (checker_mismatches),
      .results_owed   (results_owed)
   );

   // 8 ns clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Receiver: stall pattern follows bits 9:8 of the stall counter; hold off on request
   always @(posedge clock) begin
      logic take;
      stall_tick <= stall_tick + 16'd1;
      case (stall_tick[9:8])
         2'd0: take = 1'b1;
         2'd1: take = ($urandom_range(0, 1) == 0);
         2'd2: take = (stall_tick[3:0] > 4'd9);
         default: take = ($urandom_range(0, 15) == 0);
      endcase
      if (hold_off)
         take = 1'b0;
      rsp_pop <= take;
   end

   // Long receiver hold-off while the sender keeps offering samples
   initial begin
      wait (random_sent >= 150 && req_push);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Give up on a hung run
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("moving_average_deviation_top: mismatch");
      $finish;
   end

   function automatic logic signed [SAMPLE_W-1:0] pick_sample(input sample_mix_type mix);
      case (mix)
         MIX_HIGH:
            if ($urandom_range(0, 3) != 0)
               return SAMPLE_MAX;
         MIX_LOW:
            if ($urandom_range(0, 3) != 0)
               return SAMPLE_MIN;
         MIX_NEAR_ZERO:
            return $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
         default: ;
      endcase
      return $urandom;
   endfunction

   // Offer one sample and hold it until it transfers; idle between bursts
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
      int gap;
      if (burst_left == 0) begin
         req_push <= 1'b0;
         gap = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 5) : $urandom_range(1, 90);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      req_push   <= 1'b1;
      req_sample <= value;
      do
         @(posedge clock);
      while (req_full);
      burst_left--;
   endtask

   // Stop sending, let every result drain, then write the window length
   task automatic write_window_len(input logic [LEN_W-1:0] value);
      req_push <= 1'b0;
      // Let the owed count catch up with the last sample transfer
      repeat (2) @(posedge clock);
      while (results_owed != 0)
         @(posedge clock);
      csr_valid      <= 1'b1;
      csr_window_len <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic signed [SAMPLE_W-1:0] opening [7];
      logic [LEN_W-1:0]           len_corners [10];
      logic [LEN_W-1:0]           next_len;
      sample_mix_type             mix;
      int                         phase;
      int                         count;

      opening     = '{32'sd0, 32'sd1, -32'sd1, SAMPLE_MAX, SAMPLE_MIN,
                      32'sh0001_0000, SAMPLE_MAX};
      len_corners = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd31, 7'd60, 7'd63, 7'd64, 7'd65, 7'd127};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes under the reset length, before the ring fills
      foreach (opening[i])
         send_sample(opening[i]);
      // Wrap the ring at 20 with the top value, then shrink to zero length
      write_window_len(7'd20);
      repeat (13) send_sample(SAMPLE_MAX);
      write_window_len(7'd0);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);

      // Random phases; every third one loads a long window with extremes
      phase = 0;
      while (random_sent < RANDOM_ITEMS) begin
         if (phase % 3 == 0) begin
            next_len = ($urandom_range(0, 1) == 0) ? 7'd64 : 7'd127;
            mix      = ($urandom_range(0, 1) == 0) ? MIX_HIGH : MIX_LOW;
         end else begin
            next_len = ($urandom_range(0, 1) == 0) ? len_corners[$urandom_range(0, 9)]
                                                   : 7'($urandom_range(0, 127));
            mix      = sample_mix_type'($urandom_range(0, 3));
         end
         write_window_len(next_len);
         count = $urandom_range(8, 70);
         repeat (count) begin
            send_sample(pick_sample(mix));
            random_sent++;
         end
         phase++;
      end

      // Drain and give the verdict
      req_push <= 1'b0;
      repeat (2) @(posedge clock);
      while (results_owed != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (checker_mismatches == 0)
         $display("moving_average_deviation_top: match");
      else
         $display("moving_average_deviation_top: mismatch");
      $finish;
   end

endmodule
